// File: rtl/quaternion_to_euler_angles_defines.svh
// Assertion helpers for the top-level RTL. Both expect clk and rst in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define QEA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define QEA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/qea_pkg.sv
`default_nettype none

package qea_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_ITERS    = 34;
  localparam int MAG_W           = 32;
  localparam int RES_W           = 15;

  // Operands of one atan2: magnitudes and the signs of both arguments.
  typedef struct packed {
    logic [MAG_W-1:0] ux;
    logic [MAG_W-1:0] uy;
    logic             xneg;
    logic             yneg;
  } qea_vec_t;

  // Result of one atan2: output magnitude and the sign of the y argument.
  typedef struct packed {
    logic [RES_W-1:0] mag;
    logic             yneg;
  } qea_res_t;

  // Degrees to output units, with 45 degrees equal to 2^32 internally.
  localparam logic [12:0] DEG_SCALE = 13'(45 << ANGLE_FRAC_BITS);

  // atan(2^-i) with 45 degrees equal to 2^32, truncated.
  localparam logic [32:0] ATAN_TAB [CORDIC_ITERS] = '{
    33'd4294967296, 33'd2535467244, 33'd1339671258, 33'd680038048,
    33'd341338648,  33'd170835722,  33'd85438706,   33'd42721960,
    33'd21361306,   33'd10680693,   33'd5340352,    33'd2670176,
    33'd1335088,    33'd667544,     33'd333772,     33'd166886,
    33'd83443,      33'd41721,      33'd20860,      33'd10430,
    33'd5215,       33'd2607,       33'd1303,       33'd651,
    33'd325,        33'd162,        33'd81,         33'd40,
    33'd20,         33'd10,         33'd5,          33'd2,
    33'd1,          33'd0
  };

endpackage

`default_nettype wire

// File: rtl/qea_quat_if.sv
`default_nettype none

interface qea_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, output quat_w, output quat_x, output quat_y,
                 output quat_z, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y,
               input quat_z, output ready);
endinterface

`default_nettype wire

// File: rtl/qea_euler_if.sv
`default_nettype none

interface qea_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] yaw_deg;

  modport source(output valid, output roll_deg, output pitch_deg, output yaw_deg,
                 input ready);
  modport sink(input valid, input roll_deg, input pitch_deg, input yaw_deg,
               output ready);
endinterface

`default_nettype wire

// File: rtl/qea_atan2.sv
`default_nettype none

module qea_atan2 import qea_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  qea_vec_t in_vec,
  output logic     out_valid,
  output qea_res_t out_res
);

  localparam int NW         = 40;
  localparam int CW         = 43;
  localparam int ZW         = 36;
  localparam int NORM_STEPS = 6;
  localparam int LAT        = NORM_STEPS + CORDIC_ITERS + 3;
  localparam int ANG_SHIFT  = 32;

  localparam logic signed [ZW-1:0] Z_TOP      = ZW'(64'h2_0000_0000);
  localparam logic [34:0]          HALF_TURN  = 35'h4_0000_0000;
  localparam logic [47:0]          ROUND_HALF = 48'h0000_8000_0000;

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
  } side_t;

  logic [LAT-1:0]       v;
  logic [NW-1:0]        nx [NORM_STEPS];
  logic [NW-1:0]        ny [NORM_STEPS];
  side_t                ns [NORM_STEPS];
  logic signed [CW-1:0] cx [CORDIC_ITERS];
  logic signed [CW-1:0] cy [CORDIC_ITERS];
  logic signed [ZW-1:0] cz [CORDIC_ITERS];
  side_t                cs [CORDIC_ITERS];
  logic signed [ZW-1:0] zf;
  logic [33:0]          zc;
  logic [34:0]          th_next;
  logic [34:0]          th;
  logic                 th_yneg;
  logic [47:0]          prod;
  logic                 prod_yneg;
  logic [47:0]          rsum;
  qea_res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], in_valid};
    end
  end

  // Left shifts by 32, 16, ... 1 bring the larger operand into [2^39, 2^40).
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int S = 32 >> k;
    logic [NW-1:0] px;
    logic [NW-1:0] py;
    side_t         ps;
    if (k == 0) begin : g_first
      assign px = NW'(in_vec.ux);
      assign py = NW'(in_vec.uy);
      assign ps = '{zero: ((in_vec.ux | in_vec.uy) == '0),
                    xneg: in_vec.xneg, yneg: in_vec.yneg};
    end else begin : g_next
      assign px = nx[k-1];
      assign py = ny[k-1];
      assign ps = ns[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (((px | py) >> (NW - S)) == '0) begin
          nx[k] <= px << S;
          ny[k] <= py << S;
        end else begin
          nx[k] <= px;
          ny[k] <= py;
        end
        ns[k] <= ps;
      end
    end
  end

  // Vectoring CORDIC, one rotation per stage.
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [ZW-1:0] pz;
    side_t                ps;
    if (i == 0) begin : g_first
      assign px = $signed({3'b000, nx[NORM_STEPS-1]});
      assign py = $signed({3'b000, ny[NORM_STEPS-1]});
      assign pz = '0;
      assign ps = ns[NORM_STEPS-1];
    end else begin : g_next
      assign px = cx[i-1];
      assign py = cy[i-1];
      assign pz = cz[i-1];
      assign ps = cs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!py[CW-1]) begin
          cx[i] <= px + (py >>> i);
          cy[i] <= py - (px >>> i);
          cz[i] <= pz + $signed(ZW'(ATAN_TAB[i]));
        end else begin
          cx[i] <= px - (py >>> i);
          cy[i] <= py + (px >>> i);
          cz[i] <= pz - $signed(ZW'(ATAN_TAB[i]));
        end
        cs[i] <= ps;
      end
    end
  end

  assign zf = cz[CORDIC_ITERS-1];

  always_comb begin
    if (zf[ZW-1]) begin
      zc = '0;
    end else if (zf > Z_TOP) begin
      zc = Z_TOP[33:0];
    end else begin
      zc = zf[33:0];
    end
    if (cs[CORDIC_ITERS-1].zero) begin
      th_next = '0;
    end else if (cs[CORDIC_ITERS-1].xneg) begin
      th_next = HALF_TURN - 35'(zc);
    end else begin
      th_next = 35'(zc);
    end
  end

  assign rsum = prod + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      th        <= th_next;
      th_yneg   <= cs[CORDIC_ITERS-1].yneg;
      prod      <= 48'(th) * 48'(DEG_SCALE);
      prod_yneg <= th_yneg;
      res.mag   <= rsum[ANG_SHIFT +: RES_W];
      res.yneg  <= prod_yneg;
    end
  end

  assign out_valid = v[LAT-1];
  assign out_res   = res;

endmodule

`default_nettype wire

// File: rtl/quaternion_to_euler_angles.sv
// Channel  Modport  Beat contents
// quat     sink     quat_w, quat_x, quat_y, quat_z (signed, 14 fraction bits)
// euler    source   roll_deg, pitch_deg, yaw_deg (signed, 1/128 degree)
//
// One quaternion is accepted per cycle while the output is not stalled; each beat gives one result.
// The pipeline has 36 front stages (products, sums, clamp, square, 1 - s^2, 31 root steps)
// plus 43 stages per atan2 unit (normalize, 34 CORDIC steps, scaling) and
// the output register. Reset (rst, synchronous) clears only valid bits.
// A stalled output beat freezes the whole pipeline, so nothing is lost.
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles import qea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  qea_quat_if.sink           quat,
  qea_euler_if.source        euler
);

  localparam int SQRT_STEPS   = 31;
  localparam int FRONT_STAGES = 5 + SQRT_STEPS;
  localparam int DLY          = FRONT_STAGES - 3;
  localparam int PITCH_SHIFT  = 30 - 2 * QUAT_FRAC_BITS;

  localparam logic signed [33:0] P_HALF  = 34'sh1 <<< (2 * QUAT_FRAC_BITS - 1);
  localparam logic signed [33:0] P_ONE   = 34'sh1 <<< (2 * QUAT_FRAC_BITS);
  localparam logic [60:0]        RAD_ONE = 61'h1 << 60;

  function automatic logic [31:0] mag34(input logic signed [33:0] val);
    logic signed [33:0] a;
    a = val[33] ? -val : val;
    return a[31:0];
  endfunction

  logic                     en;
  logic [FRONT_STAGES-1:0]  fv;

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_xy, p_wz, p_zz, p_wy, p_xz;
  logic signed [32:0] s_rnum, s_ynum;
  logic signed [33:0] s_rden, s_yden, s_pval;
  logic signed [33:0] pclamp;
  qea_vec_t           r3_vec, y3_vec;
  logic [30:0]        sm3;
  logic               neg3;
  logic [60:0]        sq4;
  logic [30:0]        sm4;
  logic               neg4;
  logic [60:0]        rad5;
  logic [30:0]        sm5;
  logic               neg5;
  logic [60:0]        qn   [SQRT_STEPS];
  logic [61:0]        qr   [SQRT_STEPS];
  logic [30:0]        qsm  [SQRT_STEPS];
  logic               qneg [SQRT_STEPS];
  qea_vec_t           dly_r [DLY];
  qea_vec_t           dly_y [DLY];
  qea_vec_t           pitch_vec;

  logic               roll_v, pitch_v, yaw_v;
  qea_res_t           roll_res, pitch_res, yaw_res;
  logic signed [15:0] roll_val, pitch_val, yaw_val;
  logic               units_ok, pitch_ok, angles_ok;

  assign en         = !(euler.valid && !euler.ready);
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[FRONT_STAGES-2:0], quat.valid};
    end
  end

  always_comb begin
    if (s_pval > P_ONE) begin
      pclamp = P_ONE;
    end else if (s_pval < -P_ONE) begin
      pclamp = -P_ONE;
    end else begin
      pclamp = s_pval;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat.quat_w * quat.quat_x;
      p_yz <= quat.quat_y * quat.quat_z;
      p_xx <= quat.quat_x * quat.quat_x;
      p_yy <= quat.quat_y * quat.quat_y;
      p_xy <= quat.quat_x * quat.quat_y;
      p_wz <= quat.quat_w * quat.quat_z;
      p_zz <= quat.quat_z * quat.quat_z;
      p_wy <= quat.quat_w * quat.quat_y;
      p_xz <= quat.quat_x * quat.quat_z;

      s_rnum <= 33'(p_wx) + 33'(p_yz);
      s_rden <= P_HALF - 34'(p_xx) - 34'(p_yy);
      s_ynum <= 33'(p_xy) + 33'(p_wz);
      s_yden <= P_HALF - 34'(p_yy) - 34'(p_zz);
      s_pval <= (34'(p_wy) - 34'(p_xz)) <<< 1;

      r3_vec <= '{ux: mag34(s_rden), uy: mag34(34'(s_rnum)),
                  xneg: s_rden[33], yneg: s_rnum[32]};
      y3_vec <= '{ux: mag34(s_yden), uy: mag34(34'(s_ynum)),
                  xneg: s_yden[33], yneg: s_ynum[32]};
      sm3    <= 31'(mag34(pclamp) << PITCH_SHIFT);
      neg3   <= pclamp[33];

      sq4  <= 61'(sm3) * 61'(sm3);
      sm4  <= sm3;
      neg4 <= neg3;

      rad5 <= RAD_ONE - sq4;
      sm5  <= sm4;
      neg5 <= neg4;

      dly_r[0] <= r3_vec;
      dly_y[0] <= y3_vec;
      for (int k = 1; k < DLY; k++) begin
        dly_r[k] <= dly_r[k-1];
        dly_y[k] <= dly_y[k-1];
      end
    end
  end

  // Integer square root of 1 - s^2, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [61:0] B = 62'h1 << (60 - 2 * k);
    logic [60:0] pn;
    logic [61:0] pr;
    logic [30:0] psm;
    logic        pneg;
    logic [61:0] trial;
    if (k == 0) begin : g_first
      assign pn   = rad5;
      assign pr   = '0;
      assign psm  = sm5;
      assign pneg = neg5;
    end else begin : g_next
      assign pn   = qn[k-1];
      assign pr   = qr[k-1];
      assign psm  = qsm[k-1];
      assign pneg = qneg[k-1];
    end
    assign trial = pr + B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (62'(pn) >= trial) begin
          qn[k] <= 61'(62'(pn) - trial);
          qr[k] <= (pr >> 1) + B;
        end else begin
          qn[k] <= pn;
          qr[k] <= pr >> 1;
        end
        qsm[k]  <= psm;
        qneg[k] <= pneg;
      end
    end
  end

  assign pitch_vec = '{ux: {1'b0, qr[SQRT_STEPS-1][30:0]}, uy: {1'b0, qsm[SQRT_STEPS-1]},
                       xneg: 1'b0, yneg: qneg[SQRT_STEPS-1]};

  qea_atan2 u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv[FRONT_STAGES-1]),
    .in_vec    (dly_r[DLY-1]),
    .out_valid (roll_v),
    .out_res   (roll_res)
  );

  qea_atan2 u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv[FRONT_STAGES-1]),
    .in_vec    (pitch_vec),
    .out_valid (pitch_v),
    .out_res   (pitch_res)
  );

  qea_atan2 u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv[FRONT_STAGES-1]),
    .in_vec    (dly_y[DLY-1]),
    .out_valid (yaw_v),
    .out_res   (yaw_res)
  );

  assign roll_val  = {1'b0, roll_res.mag};
  assign pitch_val = {1'b0, pitch_res.mag};
  assign yaw_val   = {1'b0, yaw_res.mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      euler.valid <= 1'b0;
    end else if (en) begin
      euler.valid <= roll_v;
    end
  end

  // Yaw is reported negated, so its sign is the opposite of the y argument.
  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_deg  <= roll_res.yneg ? -roll_val : roll_val;
      euler.pitch_deg <= 15'(pitch_res.yneg ? -pitch_val : pitch_val);
      euler.yaw_deg   <= yaw_res.yneg ? yaw_val : -yaw_val;
    end
  end

  assign units_ok  = (roll_v == pitch_v) && (roll_v == yaw_v);
  assign pitch_ok  = (euler.pitch_deg <= 15'sd11520) && (euler.pitch_deg >= -15'sd11520);
  assign angles_ok = (euler.roll_deg <= 16'sd23040) && (euler.roll_deg >= -16'sd23040) &&
                     (euler.yaw_deg <= 16'sd23040) && (euler.yaw_deg >= -16'sd23040);

  `QEA_ASSERT_ALWAYS(a_units_aligned, units_ok, "atan2 units out of step")
  `QEA_ASSERT_IMPLIES(a_pitch_range, euler.valid, pitch_ok, "pitch beyond 90 degrees")
  `QEA_ASSERT_IMPLIES(a_roll_yaw_range, euler.valid, angles_ok, "roll or yaw beyond 180 degrees")

endmodule

`default_nettype wire
